FILE: design/direct_mapped_read_cache_top_defines.svh
// assertion macros for the direct-mapped read cache checker
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef DIRECT_MAPPED_READ_CACHE_TOP_DEFINES_SVH
`define DIRECT_MAPPED_READ_CACHE_TOP_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define DMRC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define DMRC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/dmrc_pkg.sv
// shared types and constants of the direct-mapped read cache
// no dependencies; imported by every module of the block
`default_nettype none

package dmrc_pkg;

  // geometry, fixed by the address split of the result fields
  localparam int unsigned LINE_BYTES = 16;
  localparam int unsigned NUM_LINES  = 8;
  localparam int unsigned MEM_BYTES  = 4096;

  localparam int unsigned ADDR_W  = 12;
  localparam int unsigned OFF_W   = $clog2(LINE_BYTES);
  localparam int unsigned LINE_W  = $clog2(NUM_LINES);
  localparam int unsigned TAG_W   = ADDR_W - OFF_W - LINE_W;
  localparam int unsigned MEM_AW  = $clog2(MEM_BYTES);
  localparam int unsigned FILL_W  = OFF_W + 1;
  localparam int unsigned DATA_W  = 8;
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned COST_W  = 8;

  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [COST_W-1:0] HIT_COST_RST  = 8'd1;
  localparam logic [COST_W-1:0] MISS_COST_RST = 8'd20;
  localparam logic [DATA_W-1:0] LINE_FILL     = 8'h23;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HIT_COST  = 1'b0,
    CFG_MISS_COST = 1'b1
  } cfg_reg_e;

  typedef enum logic {
    ACT_LOAD = 1'b0,
    ACT_READ = 1'b1
  } action_e;

  // request to the line store: lookup/read, byte fill and tag update
  typedef struct packed {
    logic              rd_en;
    logic [LINE_W-1:0] rd_line;
    logic [OFF_W-1:0]  rd_off;
    logic [TAG_W-1:0]  tag;
    logic              wr_en;
    logic [LINE_W-1:0] wr_line;
    logic [OFF_W-1:0]  wr_off;
    logic [DATA_W-1:0] wr_data;
    logic              tag_wr;
  } lines_req_t;

  // request to the backing memory
  typedef struct packed {
    logic              wr_en;
    logic              rd_en;
    logic [MEM_AW-1:0] addr;
    logic [DATA_W-1:0] wdata;
  } mem_req_t;

endpackage

`default_nettype wire

FILE: design/dmrc_sat_add.sv
// saturating adder shared by the three running counters
// depends on dmrc_pkg
`default_nettype none

module dmrc_sat_add import dmrc_pkg::*; (
  input  wire logic [CNT_W-1:0]  acc_i,
  input  wire logic [COST_W-1:0] inc_i,
  output logic      [CNT_W-1:0]  sum_o
);

  logic [CNT_W:0] wide_sum;

  // one extra bit catches the wrap, which clamps to all ones
  assign wide_sum = {1'b0, acc_i} + (CNT_W + 1)'(inc_i);
  assign sum_o    = wide_sum[CNT_W] ? {CNT_W{1'b1}} : wide_sum[CNT_W-1:0];

endmodule

`default_nettype wire

FILE: design/dmrc_backing_mem.sv
// backing memory: one write and one registered read per cycle
// depends on dmrc_pkg
`default_nettype none

module dmrc_backing_mem import dmrc_pkg::*; (
  input  wire logic              clk_i,
  input  wire mem_req_t          req_i,
  output logic      [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [MEM_BYTES];
  logic [DATA_W-1:0] rdata_q;

  // contents stay undefined until loaded
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.addr] <= req_i.wdata;
    end
    if (req_i.rd_en) begin
      rdata_q <= mem[req_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: design/dmrc_lines.sv
// line store: byte array, tags, valid bits and the tag compare
// depends on dmrc_pkg
`default_nettype none

module dmrc_lines import dmrc_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire lines_req_t        req_i,
  output logic                   hit_o,
  output logic      [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] data_mem [LINE_BYTES*NUM_LINES];
  logic [DATA_W-1:0] rdata_q;
  logic [TAG_W-1:0]  tag_q [NUM_LINES];
  logic [NUM_LINES-1:0] valid_q;

  // line bytes are read on every lookup but used only on a hit, so unwritten bytes never show
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      data_mem[{req_i.wr_line, req_i.wr_off}] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rdata_q <= data_mem[{req_i.rd_line, req_i.rd_off}];
    end
  end

  // tags and valid bits, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      for (int i = 0; i < NUM_LINES; i++) begin
        tag_q[i] <= '0;
      end
    end else if (req_i.tag_wr) begin
      tag_q[req_i.wr_line]   <= req_i.tag;
      valid_q[req_i.wr_line] <= 1'b1;
    end
  end

  // hit when the indexed line is valid and holds the same tag
  assign hit_o   = valid_q[req_i.rd_line] && (tag_q[req_i.rd_line] == req_i.tag);
  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: design/direct_mapped_read_cache_top.sv
// direct-mapped read cache, top level with the access sequencer
// depends on dmrc_pkg, dmrc_lines, dmrc_backing_mem, dmrc_sat_add
//
// usage:
//   command channel: a transaction is taken at a clock edge with start high
//   and busy low; action_i 0 loads load_byte_i into the backing memory at
//   address_i, action_i 1 reads that address through the cache.
//   result: done_o is high for exactly one cycle with hit, read byte, the
//   address split and the three saturating counters; the receiver cannot
//   stall it and the values hold until the next command is taken.
//   config: cfg_valid_i/cfg_ready_o write hit cost (index 0) or miss cost
//   (index 1); ready is always high, write only while busy is low.
// sequence: a load writes the backing memory in LOOKUP and ends; a read hit runs
//   LOOKUP, ACCESS, TIME; a read miss runs LOOKUP, REFILL, FAULT, ACCESS, TIME. a miss
//   walks the line through the single registered backing-memory read port, one byte
//   a cycle, and the three counters share one saturating adder, one counter a cycle.
//   done_o rises in the cycle busy falls.
// reset: all lines invalid, counters zero, hit cost 1, miss cost 20.
//   backing memory is not cleared and must be loaded before it is read.
`default_nettype none

module direct_mapped_read_cache_top import dmrc_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // command channel
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic                 action_i,
  input  wire logic [ADDR_W-1:0]    address_i,
  input  wire logic [DATA_W-1:0]    load_byte_i,
  // result strobe
  output logic                      done_o,
  output logic                      hit_o,
  output logic      [DATA_W-1:0]    read_byte_o,
  output logic      [TAG_W-1:0]     tag_field_o,
  output logic      [LINE_W-1:0]    line_field_o,
  output logic      [OFF_W-1:0]     offset_field_o,
  output logic      [CNT_W-1:0]     faults_o,
  output logic      [CNT_W-1:0]     accesses_o,
  output logic      [CNT_W-1:0]     elapsed_o,
  // configuration write channel
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [COST_W-1:0]    cfg_data_i
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_REFILL,
    ST_FAULT,
    ST_ACCESS,
    ST_TIME
  } state_e;

  state_e            state_q;
  action_e           action_q;
  logic [ADDR_W-1:0] address_q;
  logic [DATA_W-1:0] load_byte_q;
  logic [FILL_W-1:0] fill_q;
  logic              hit_q;
  logic [DATA_W-1:0] data_q;
  logic              done_q;
  logic [CNT_W-1:0]  faults_q;
  logic [CNT_W-1:0]  accesses_q;
  logic [CNT_W-1:0]  elapsed_q;
  logic [COST_W-1:0] hit_cost_q;
  logic [COST_W-1:0] miss_cost_q;

  logic [TAG_W-1:0]  tag_f;
  logic [LINE_W-1:0] line_f;
  logic [OFF_W-1:0]  off_f;
  logic [FILL_W-1:0] fill_prev;
  logic              fill_done;

  lines_req_t        lines_req;
  logic              lines_hit;
  logic [DATA_W-1:0] lines_rdata;
  mem_req_t          mem_req;
  logic [DATA_W-1:0] mem_rdata;

  logic [CNT_W-1:0]  add_acc;
  logic [COST_W-1:0] add_inc;
  logic [CNT_W-1:0]  add_sum;

  // address split
  assign tag_f     = address_q[ADDR_W-1 -: TAG_W];
  assign line_f    = address_q[OFF_W +: LINE_W];
  assign off_f     = address_q[OFF_W-1:0];
  assign fill_prev = fill_q - FILL_W'(1);
  assign fill_done = (fill_q == FILL_W'(LINE_BYTES));

  // line store requests: lookup in LOOKUP, byte fill in the cycle after its fetch
  always_comb begin
    lines_req         = '0;
    lines_req.rd_en   = (state_q == ST_LOOKUP);
    lines_req.rd_line = line_f;
    lines_req.rd_off  = off_f;
    lines_req.tag     = tag_f;
    lines_req.wr_en   = (state_q == ST_REFILL) && (fill_q != '0);
    lines_req.wr_line = line_f;
    lines_req.wr_off  = fill_prev[OFF_W-1:0];
    lines_req.wr_data = mem_rdata;
    lines_req.tag_wr  = (state_q == ST_REFILL) && fill_done;
  end

  // backing memory requests: load write or line fetch
  always_comb begin
    mem_req       = '0;
    mem_req.wr_en = (state_q == ST_LOOKUP) && (action_q == ACT_LOAD);
    mem_req.rd_en = (state_q == ST_REFILL) && !fill_done;
    mem_req.wdata = load_byte_q;
    if (mem_req.wr_en) begin
      mem_req.addr = address_q[MEM_AW-1:0];
    end else begin
      mem_req.addr = {tag_f, line_f, fill_q[OFF_W-1:0]};
    end
  end

  // operand select for the shared counter adder
  always_comb begin
    unique case (state_q)
      ST_FAULT: begin
        add_acc = faults_q;
        add_inc = COST_W'(1);
      end
      ST_ACCESS: begin
        add_acc = accesses_q;
        add_inc = COST_W'(1);
      end
      default: begin
        add_acc = elapsed_q;
        add_inc = hit_q ? hit_cost_q : miss_cost_q;
      end
    endcase
  end

  dmrc_lines u_lines (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (lines_req),
    .hit_o   (lines_hit),
    .rdata_o (lines_rdata)
  );

  dmrc_backing_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  dmrc_sat_add u_add (
    .acc_i (add_acc),
    .inc_i (add_inc),
    .sum_o (add_sum)
  );

  // sequencer with its registered results and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      action_q    <= ACT_LOAD;
      address_q   <= '0;
      load_byte_q <= '0;
      fill_q      <= '0;
      hit_q       <= 1'b0;
      data_q      <= '0;
      done_q      <= 1'b0;
      faults_q    <= '0;
      accesses_q  <= '0;
      elapsed_q   <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (start) begin
            action_q    <= action_e'(action_i);
            address_q   <= address_i;
            load_byte_q <= load_byte_i;
            state_q     <= ST_LOOKUP;
          end
        end
        ST_LOOKUP: begin
          if (action_q == ACT_LOAD) begin
            hit_q   <= 1'b0;
            data_q  <= '0;
            done_q  <= 1'b1;
            state_q <= ST_IDLE;
          end else if (lines_hit) begin
            hit_q   <= 1'b1;
            state_q <= ST_ACCESS;
          end else begin
            hit_q   <= 1'b0;
            fill_q  <= '0;
            state_q <= ST_REFILL;
          end
        end
        ST_REFILL: begin
          fill_q <= fill_q + FILL_W'(1);
          // the requested byte passes by during the fill
          if ((fill_q != '0) && (fill_prev[OFF_W-1:0] == off_f)) begin
            data_q <= mem_rdata;
          end
          if (fill_done) begin
            state_q <= ST_FAULT;
          end
        end
        ST_FAULT: begin
          faults_q <= add_sum;
          state_q  <= ST_ACCESS;
        end
        ST_ACCESS: begin
          accesses_q <= add_sum;
          if (hit_q) begin
            data_q <= lines_rdata;
          end
          state_q <= ST_TIME;
        end
        ST_TIME: begin
          elapsed_q <= add_sum;
          done_q    <= 1'b1;
          state_q   <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // cost registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_cost_q  <= HIT_COST_RST;
      miss_cost_q <= MISS_COST_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_HIT_COST:  hit_cost_q  <= cfg_data_i;
        CFG_MISS_COST: miss_cost_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign busy           = (state_q != ST_IDLE);
  assign cfg_ready_o    = 1'b1;
  assign done_o         = done_q;
  assign hit_o          = hit_q;
  assign read_byte_o    = data_q;
  assign tag_field_o    = tag_f;
  assign line_field_o   = line_f;
  assign offset_field_o = off_f;
  assign faults_o       = faults_q;
  assign accesses_o     = accesses_q;
  assign elapsed_o      = elapsed_q;

endmodule

`default_nettype wire

FILE: design/dmrc_checker.sv
// port-level checks of the direct-mapped read cache, bound to the top level
// depends on dmrc_pkg and direct_mapped_read_cache_top_defines.svh
`default_nettype none

`include "direct_mapped_read_cache_top_defines.svh"

module dmrc_checker import dmrc_pkg::*; (
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 start,
  input wire logic                 busy,
  input wire logic                 action_i,
  input wire logic                 done_o,
  input wire logic                 hit_o,
  input wire logic [CNT_W-1:0]     faults_o,
  input wire logic [CNT_W-1:0]     accesses_o
);

  // an accepted command keeps the block busy
  `DMRC_ASSERT_NEXT(a_busy_after_start, start && !busy, busy, "busy low after a command")

  // the result strobe comes with the block free again
  `DMRC_ASSERT_NOW(a_done_not_busy, done_o, !busy, "result strobe while busy")

  // a load ends with the result strobe once its lookup state is done
  `DMRC_ASSERT_NOW(a_load_latency, start && !busy && !action_i, ##2 done_o, "load result late")

  // the access count never goes down
  `DMRC_ASSERT_NOW(a_access_mono, 1'b1, accesses_o >= $past(accesses_o), "access count fell")

  // a hit leaves the fault count alone
  `DMRC_ASSERT_NOW(a_hit_no_fault, done_o && hit_o, $stable(faults_o), "fault count moved on hit")

endmodule

bind direct_mapped_read_cache_top dmrc_checker u_dmrc_checker (.*);

`default_nettype wire
